FILE: rtl/core/pfe_pkg.sv
// shared types, codes and letter helpers for the playfair pair encryptor
`default_nettype none
package pfe_pkg;

  localparam int SQ_SIDE   = 5;
  localparam int NUM_LANES = SQ_SIDE * SQ_SIDE;
  localparam int LANE_W    = 5;
  localparam int ROW_W     = 3;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_Z = 8'h7a;
  localparam logic [7:0] CHAR_X = 8'h78;

  // lane = letter code with j folded onto i and the gap closed
  localparam logic [LANE_W-1:0] CODE_J = 5'd9;
  localparam logic [LANE_W-1:0] LANE_X = 5'd22;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_ENC   = 2'd2;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_ENC   = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] letter_a;
    logic [7:0] letter_b;
    logic       second_valid;
  } pfe_in_t;

  typedef struct packed {
    logic [7:0] cipher_a;
    logic [7:0] cipher_b;
    logic       bad_letter;
  } pfe_out_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [LANE_W-1:0] a;
    logic [LANE_W-1:0] b;
    logic              bad;
  } op_t;

  function automatic logic is_lower(input logic [7:0] ch);
    return (ch >= CHAR_A) && (ch <= CHAR_Z);
  endfunction

  function automatic logic [LANE_W-1:0] letter_lane(input logic [7:0] ch);
    logic [7:0] c;
    c = ch - CHAR_A;
    if (c[LANE_W-1:0] >= CODE_J) begin
      return c[LANE_W-1:0] - 5'd1;
    end
    return c[LANE_W-1:0];
  endfunction

  function automatic logic [7:0] lane_char(input logic [LANE_W-1:0] lane);
    logic [LANE_W-1:0] code;
    code = (lane >= CODE_J) ? lane + 5'd1 : lane;
    return CHAR_A + {3'b000, code};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/playfair_digraph_encrypt_core.sv
// Playfair pair encryptor over a 5x5 key square, with key clear and key letter entry.
// Items enter through a push/full port, are decoded in the front end and wait in a
// QUEUE_DEPTH-entry queue; the back end keeps one square position per letter and
// finds both letters and both cipher letters by parallel compare over the 25 lanes.
// Sustained rate is one item per cycle, set by the issue of one queue entry per cycle,
// as long as results are popped. An encrypt result passes through the queue, the
// lookup register and the result register before it reaches the out port; key and
// clear items give no result.
`default_nettype none
module playfair_digraph_encrypt_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              in_push,
  output logic                    in_full,
  input  wire  pfe_pkg::pfe_in_t  in_data,
  input  wire  logic              out_pop,
  output logic                    out_empty,
  output pfe_pkg::pfe_out_t       out_data
);
  import pfe_pkg::*;

  logic in_take;
  logic op_push;
  op_t  front_op;
  logic q_valid;
  op_t  q_op;
  logic q_take;

  assign in_take = in_push && !in_full;

  pfe_front u_front (
    .in_data (in_data),
    .in_take (in_take),
    .op_push (op_push),
    .op      (front_op)
  );

  pfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (op_push),
    .push_op    (front_op),
    .full       (in_full),
    .pop        (q_take),
    .head_valid (q_valid),
    .head_op    (q_op)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op        (q_op),
    .op_take   (q_take),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/core/pfe_front.sv
// front end: decodes input items into key and encrypt operations
`default_nettype none
module pfe_front (
  input  wire  pfe_pkg::pfe_in_t in_data,
  input  wire  logic             in_take,
  output logic                   op_push,
  output pfe_pkg::op_t           op
);
  import pfe_pkg::*;

  logic [7:0] byte_b;
  logic       keep;

  always_comb begin
    byte_b  = in_data.second_valid ? in_data.letter_b : CHAR_X;
    op.kind = OP_ENC;
    op.a    = letter_lane(in_data.letter_a);
    op.b    = letter_lane(byte_b);
    op.bad  = !is_lower(in_data.letter_a) || !is_lower(byte_b);
    keep    = 1'b0;
    unique case (in_data.mode)
      MODE_CLEAR: begin
        op.kind = OP_CLEAR;
        keep    = 1'b1;
      end
      MODE_ADD: begin
        op.kind = OP_ADD;
        // non-letters never reach the key
        keep    = is_lower(in_data.letter_a);
      end
      MODE_ENC: begin
        op.kind = OP_ENC;
        keep    = 1'b1;
        // doubled letter turns the second into x
        if (op.a == op.b) begin
          op.b = LANE_X;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    op_push = in_take && keep;
  end

endmodule
`default_nettype wire

FILE: rtl/core/pfe_queue.sv
// small fifo of decoded operations between front and back
`default_nettype none
module pfe_queue #(
  parameter int DEPTH = 4
) (
  input  wire  logic         clk,
  input  wire  logic         rst_n,
  input  wire  logic         push,
  input  wire  pfe_pkg::op_t push_op,
  output logic               full,
  input  wire  logic         pop,
  output logic               head_valid,
  output pfe_pkg::op_t       head_op
);
  import pfe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pfe_back.sv
// back end: key square lanes, position lookup, rule select and result register
`default_nettype none
module pfe_back (
  input  wire  logic         clk,
  input  wire  logic         rst_n,
  input  wire  logic         op_valid,
  input  wire  pfe_pkg::op_t op,
  output logic               op_take,
  input  wire  logic         out_pop,
  output logic               out_empty,
  output pfe_pkg::pfe_out_t  out_data
);
  import pfe_pkg::*;

  // per letter lane: its place in the square and whether it came from the key
  logic [LANE_W-1:0]    pos_r [NUM_LANES];
  logic [LANE_W-1:0]    pos_nxt [NUM_LANES];
  logic [NUM_LANES-1:0] used_r, used_nxt;
  logic [LANE_W-1:0]    count_r, count_nxt;

  logic                 s2_valid_r, s2_valid_nxt;
  logic [LANE_W-1:0]    s2_ta_r, s2_tb_r;
  logic                 s2_bad_r;
  logic                 s2_adv;

  logic                 out_valid_r, out_valid_nxt;
  pfe_out_t             out_r;

  logic [LANE_W-1:0]    pa, pb, ta, tb;
  logic                 a_used;
  logic [ROW_W-1:0]     r1, c1, r2, c2;
  logic [LANE_W-1:0]    la, lb;

  function automatic logic [ROW_W-1:0] pos_row(input logic [LANE_W-1:0] p);
    if (p >= LANE_W'(4 * SQ_SIDE)) return ROW_W'(4);
    if (p >= LANE_W'(3 * SQ_SIDE)) return ROW_W'(3);
    if (p >= LANE_W'(2 * SQ_SIDE)) return ROW_W'(2);
    if (p >= LANE_W'(SQ_SIDE)) return ROW_W'(1);
    return ROW_W'(0);
  endfunction

  function automatic logic [ROW_W-1:0] pos_col(input logic [LANE_W-1:0] p);
    logic [ROW_W-1:0]  r;
    logic [LANE_W-1:0] base;
    r    = pos_row(p);
    base = {r, 2'b00} + {2'b00, r};
    return ROW_W'(p - base);
  endfunction

  function automatic logic [LANE_W-1:0] rc_pos(input logic [ROW_W-1:0] r,
                                               input logic [ROW_W-1:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [ROW_W-1:0] wrap_inc(input logic [ROW_W-1:0] v);
    return (v == ROW_W'(SQ_SIDE - 1)) ? '0 : v + ROW_W'(1);
  endfunction

  assign s2_adv    = s2_valid_r && (!out_valid_r || out_pop);
  // key updates at issue see every earlier lookup already done or leaving now
  assign op_take   = op_valid && (!s2_valid_r || s2_adv);
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // issue: parallel compare selects the positions of both letters
  always_comb begin
    pa     = '0;
    pb     = '0;
    a_used = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (LANE_W'(l) == op.a) begin
        pa     = pa | pos_r[l];
        a_used = a_used | used_r[l];
      end
      if (LANE_W'(l) == op.b) begin
        pb = pb | pos_r[l];
      end
    end
    r1 = pos_row(pa);
    c1 = pos_col(pa);
    r2 = pos_row(pb);
    c2 = pos_col(pb);
    if (r1 == r2) begin
      ta = rc_pos(r1, wrap_inc(c1));
      tb = rc_pos(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      ta = rc_pos(wrap_inc(r1), c1);
      tb = rc_pos(wrap_inc(r2), c2);
    end else begin
      ta = rc_pos(r1, c2);
      tb = rc_pos(r2, c1);
    end
  end

  // key square update
  always_comb begin
    pos_nxt   = pos_r;
    used_nxt  = used_r;
    count_nxt = count_r;
    if (op_take) begin
      unique case (op.kind)
        OP_CLEAR: begin
          for (int l = 0; l < NUM_LANES; l++) begin
            pos_nxt[l] = LANE_W'(l);
          end
          used_nxt  = '0;
          count_nxt = '0;
        end
        OP_ADD: begin
          // the new key letter leaves its free slot; free letters ahead of it move up one
          if (!a_used && (count_r < LANE_W'(NUM_LANES))) begin
            for (int l = 0; l < NUM_LANES; l++) begin
              if (LANE_W'(l) == op.a) begin
                pos_nxt[l]  = count_r;
                used_nxt[l] = 1'b1;
              end else if (!used_r[l] && (pos_r[l] < pa)) begin
                pos_nxt[l] = pos_r[l] + LANE_W'(1);
              end
            end
            count_nxt = count_r + LANE_W'(1);
          end
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (op_take && (op.kind == OP_ENC)) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_adv) begin
      s2_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // reverse lookup: which lane sits at each target place
  always_comb begin
    la = '0;
    lb = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (pos_r[l] == s2_ta_r) begin
        la = la | LANE_W'(l);
      end
      if (pos_r[l] == s2_tb_r) begin
        lb = lb | LANE_W'(l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        pos_r[l] <= LANE_W'(l);
      end
      used_r      <= '0;
      count_r     <= '0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && (op.kind == OP_ENC)) begin
      s2_ta_r  <= ta;
      s2_tb_r  <= tb;
      s2_bad_r <= op.bad;
    end
    if (s2_adv) begin
      out_r.cipher_a   <= s2_bad_r ? 8'h00 : lane_char(la);
      out_r.cipher_b   <= s2_bad_r ? 8'h00 : lane_char(lb);
      out_r.bad_letter <= s2_bad_r;
    end
  end

endmodule
`default_nettype wire

FILE: sim/playfair_digraph_encrypt_core_tb.sv
// self-checking testbench for the playfair pair encryptor: directed and random queue traffic against a predictor
`timescale 1ns / 1ps

class cipher_tracker;
  localparam int CODE_I = 8;
  localparam int CODE_J = 9;
  localparam int CODE_X = 23;
  localparam int SIDE   = pfe_pkg::SQ_SIDE;
  localparam int CELLS  = SIDE * SIDE;

  bit [4:0]          key_seq[CELLS];
  int                key_len;
  bit [25:0]         key_used;
  pfe_pkg::pfe_out_t pending_cipher[$];
  int                mismatches;

  function new();
    key_len    = 0;
    key_used   = '0;
    mismatches = 0;
  endfunction

  // letter code 0..25 with j folded onto i, -1 for anything outside a-z
  function int letter_code(logic [7:0] ch);
    int c;
    if (ch < pfe_pkg::CHAR_A || ch > pfe_pkg::CHAR_Z) begin
      return -1;
    end
    c = int'(ch - pfe_pkg::CHAR_A);
    if (c == CODE_J) begin
      c = CODE_I;
    end
    return c;
  endfunction

  function pfe_pkg::pfe_out_t encrypt_pair(logic [7:0] la, logic [7:0] lb, logic has_b);
    pfe_pkg::pfe_out_t res;
    int a, b, k, c, r1, c1, r2, c2, oa, ob;
    int sq[CELLS];
    int where[26];
    res = '0;
    a = letter_code(la);
    b = has_b ? letter_code(lb) : CODE_X;
    if (a < 0 || b < 0) begin
      res.bad_letter = 1'b1;
      return res;
    end
    if (a == b) begin
      b = CODE_X;
    end
    // key letters first, then the unused rest of the alphabet without j
    for (k = 0; k < key_len; k++) begin
      sq[k] = key_seq[k];
    end
    k = key_len;
    for (c = 0; c < 26 && k < CELLS; c++) begin
      if (c != CODE_J && !key_used[c]) begin
        sq[k] = c;
        k++;
      end
    end
    foreach (where[i]) begin
      where[i] = 0;
    end
    for (k = 0; k < CELLS; k++) begin
      where[sq[k]] = k;
    end
    r1 = where[a] / SIDE;
    c1 = where[a] % SIDE;
    r2 = where[b] / SIDE;
    c2 = where[b] % SIDE;
    if (r1 == r2) begin
      oa = sq[r1 * SIDE + (c1 + 1) % SIDE];
      ob = sq[r2 * SIDE + (c2 + 1) % SIDE];
    end else if (c1 == c2) begin
      oa = sq[((r1 + 1) % SIDE) * SIDE + c1];
      ob = sq[((r2 + 1) % SIDE) * SIDE + c2];
    end else begin
      oa = sq[r1 * SIDE + c2];
      ob = sq[r2 * SIDE + c1];
    end
    res.cipher_a = pfe_pkg::CHAR_A + 8'(oa);
    res.cipher_b = pfe_pkg::CHAR_A + 8'(ob);
    return res;
  endfunction

  function void note_push(pfe_pkg::pfe_in_t it);
    int a;
    case (it.mode)
      pfe_pkg::MODE_CLEAR: begin
        key_len  = 0;
        key_used = '0;
      end
      pfe_pkg::MODE_ADD: begin
        a = letter_code(it.letter_a);
        if (a >= 0 && !key_used[a] && key_len < CELLS) begin
          key_seq[key_len] = 5'(a);
          key_len++;
          key_used[a] = 1'b1;
        end
      end
      pfe_pkg::MODE_ENC: begin
        pending_cipher.push_back(encrypt_pair(it.letter_a, it.letter_b, it.second_valid));
      end
      default: begin
      end
    endcase
  endfunction

  function void check_pop(pfe_pkg::pfe_out_t got);
    pfe_pkg::pfe_out_t want;
    if (pending_cipher.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result with nothing pending: a=%h b=%h bad=%b", $time,
                 got.cipher_a, got.cipher_b, got.bad_letter);
      end
      return;
    end
    want = pending_cipher.pop_front();
    if (got.cipher_a !== want.cipher_a || got.cipher_b !== want.cipher_b ||
        got.bad_letter !== want.bad_letter) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch cipher_a exp %h got %h, cipher_b exp %h got %h, bad exp %b got %b",
                 $time, want.cipher_a, got.cipher_a, want.cipher_b, got.cipher_b,
                 want.bad_letter, got.bad_letter);
      end
    end
  endfunction
endclass

module playfair_digraph_encrypt_core_tb;
  import pfe_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         ITEM_TARGET = 1750;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     in_push = 1'b0;
  pfe_in_t  in_data = '0;
  logic     out_pop = 1'b0;
  logic     in_full;
  logic     out_empty;
  pfe_out_t out_data;

  cipher_tracker tracker = new();
  bit            quiet;
  int            counted;
  int            cycle_count;
  int            pop_hold;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  playfair_digraph_encrypt_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

  // mostly short gaps, a few long ones, none during quiet stretches
  function automatic int idle_len();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(input logic [1:0] mode, input logic [7:0] la, input logic [7:0] lb,
                           input logic sv);
    pfe_in_t it;
    int      gap;
    it.mode         = mode;
    it.letter_a     = la;
    it.letter_b     = lb;
    it.second_valid = sv;
    in_data <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    tracker.note_push(it);
    if (mode != MODE_IDLE && !(mode == MODE_ADD && (la < CHAR_A || la > CHAR_Z))) begin
      counted++;
    end
    gap = idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: check each transfer, then decide the next pop
  initial begin
    pop_hold = 0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        tracker.check_pop(out_data);
      end
      if (!rst_n) begin
        out_pop <= 1'b0;
      end else if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else begin
        out_pop <= 1'b1;
        pop_hold = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("playfair_digraph_encrypt_core_tb failed");
      $finish;
    end
  end

  initial begin
    string      key_word;
    logic [7:0] la;
    logic [7:0] lb;
    logic       sv;
    int         nkeys;
    int         npairs;
    int         r;
    cycle_count = 0;
    counted     = 0;
    quiet       = 1'b0;
    key_word    = "monarchy";
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: classic key, then each rule and each odd byte
    push_item(MODE_CLEAR, 8'h00, 8'h00, 1'b0);
    for (int i = 0; i < key_word.len(); i++) begin
      push_item(MODE_ADD, key_word[i], 8'hff, 1'b1);
    end
    push_item(MODE_ADD, "j", 8'h00, 1'b0);
    push_item(MODE_ADD, "m", 8'h00, 1'b1);
    push_item(MODE_ADD, 8'hff, 8'hff, 1'b1);
    push_item(MODE_IDLE, 8'hff, 8'hff, 1'b1);
    push_item(MODE_ENC, "a", "r", 1'b1);
    push_item(MODE_ENC, "m", "u", 1'b1);
    push_item(MODE_ENC, "h", "s", 1'b1);
    push_item(MODE_ENC, "j", "a", 1'b1);
    push_item(MODE_ENC, "b", 8'h00, 1'b0);
    push_item(MODE_ENC, "e", "e", 1'b1);
    push_item(MODE_ENC, "x", "x", 1'b1);
    push_item(MODE_ENC, "x", 8'hff, 1'b0);
    push_item(MODE_ENC, 8'h00, "a", 1'b1);
    push_item(MODE_ENC, 8'hff, 8'hff, 1'b1);
    push_item(MODE_ENC, 8'h60, 8'h7b, 1'b1);
    push_item(MODE_ENC, "A", "b", 1'b1);
    push_item(MODE_ENC, "a", 8'hff, 1'b0);

    // random: usually a fresh key, then a burst of pairs, with some noise mixed in
    while (counted < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        push_item(MODE_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
      end
      nkeys = $urandom_range(0, 30);
      repeat (nkeys) begin
        if ($urandom_range(0, 9) == 0) begin
          la = 8'($urandom);
        end else begin
          la = CHAR_A + 8'($urandom_range(0, 25));
        end
        push_item(MODE_ADD, la, 8'($urandom), 1'($urandom));
      end
      npairs = $urandom_range(4, 40);
      repeat (npairs) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          push_item(MODE_IDLE, 8'($urandom), 8'($urandom), 1'($urandom));
        end else if (r < 5) begin
          push_item(MODE_ADD, CHAR_A + 8'($urandom_range(0, 25)), 8'($urandom), 1'b1);
        end else begin
          la = ($urandom_range(0, 19) == 0) ? 8'($urandom) : CHAR_A + 8'($urandom_range(0, 25));
          lb = ($urandom_range(0, 19) == 0) ? 8'($urandom) : CHAR_A + 8'($urandom_range(0, 25));
          sv = ($urandom_range(0, 9) != 0);
          if ($urandom_range(0, 9) == 0) begin
            lb = la;
          end
          push_item(MODE_ENC, la, lb, sv);
        end
      end
    end

    in_push <= 1'b0;
    quiet = 1'b0;
    while (tracker.pending_cipher.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_cipher.size() == 0) begin
      $display("playfair_digraph_encrypt_core_tb passed");
    end else begin
      $display("playfair_digraph_encrypt_core_tb failed");
    end
    $finish;
  end

endmodule
